@@ rtl/bsm_pkg.sv @@
// Shared types, codes and constants of the bank switch mapper.
`timescale 1ns / 1ps

package bsm_pkg;

    typedef enum logic [1:0] {
        OP_CPU_READ  = 2'd0,
        OP_CPU_WRITE = 2'd1,
        OP_VIDEO     = 2'd2,
        OP_TICK      = 2'd3
    } op_t;

    // Mapper register selected by address bits 14:13 and bit 0.
    typedef enum logic [2:0] {
        REG_BANK_SELECT = 3'd0,
        REG_BANK_DATA   = 3'd1,
        REG_MIRROR      = 3'd2,
        REG_RAM_PROTECT = 3'd3,
        REG_IRQ_LATCH   = 3'd4,
        REG_IRQ_RELOAD  = 3'd5,
        REG_IRQ_DISABLE = 3'd6,
        REG_IRQ_ENABLE  = 3'd7
    } reg_sel_t;

    localparam logic [15:0] WRAM_LO         = 16'h6000;
    localparam logic [15:0] WRAM_HI         = 16'h7FFF;
    localparam logic [15:0] VIDEO_TOP       = 16'h2000;
    localparam logic [8:0]  TICK_DOT        = 9'd260;
    localparam logic [9:0]  VISIBLE_ROWS    = 10'd240;
    localparam logic [7:0]  RENDER_BITS     = 8'h18;
    localparam int          SEL_CHR_INVERT  = 7;
    localparam int          SEL_PRG_SWAP    = 6;
    localparam logic [5:0]  PRG_BANKS_RESET = 6'd2;

    typedef struct packed {
        logic [18:0] mapped_address;
        logic [7:0]  read_data;
        logic        claimed;
        logic        ram_access;
        logic        irq_line;
        logic        mirror_horizontal;
    } result_t;

    // Last 8 KB program bank, modulo 64; it doubles as the bank mask.
    function automatic logic [5:0] bank_last(input logic [5:0] banks_16k);
        return {banks_16k[4:0], 1'b0} - 6'd1;
    endfunction

    function automatic logic [5:0] bank_second_last(input logic [5:0] banks_16k);
        return {banks_16k[4:0], 1'b0} - 6'd2;
    endfunction

endpackage

@@ rtl/bsm_wram.sv @@
// Single-port work RAM with a registered read.
`timescale 1ns / 1ps

module bsm_wram #(
    parameter int DEPTH  = 8192,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic              re,
    input  logic [ADDR_W-1:0] addr,
    input  logic [7:0]        wdata,
    output logic [7:0]        rdata
);

    logic [7:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[addr];
        end
    end

endmodule

@@ rtl/bank_switch_mapper_with_line_irq.sv @@
// Top level of the bank switch mapper with the scanline interrupt counter.
`timescale 1ns / 1ps

// Channel   Direction  Handshake                   Carries
// s_axis    in         s_axis_tvalid/s_axis_tready one access or tick request
// m_axis    out        m_axis_tvalid/m_axis_tready one result per request
// cfg       in         cfg_valid/cfg_ready         program ROM size, 16 KB units
//
// One request is taken every cycle unless the skid register is full or the
// clearing pass runs; its result is registered in the result stage. A skid
// register behind the result stage keeps the input side open for one more
// request while the output stalls. After reset a clearing pass zeroes all
// WORK_RAM_BYTES bytes (8192 by default) of the work RAM, one byte a cycle; no
// request is taken meanwhile, while configuration writes are taken at any time.

module bank_switch_mapper_with_line_irq #(
    parameter int WORK_RAM_BYTES = 8192
) (
    input  logic        clk,
    input  logic        rst_n,
    // Input requests.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // From bit 0: address[15:0], write_data[23:16], scanline_row[33:24],
    // dot_cycle[42:34], render_mask[50:43], zero fill[55:51].
    input  logic [55:0] s_axis_tdata,
    // From bit 0: operation[1:0].
    input  logic [1:0]  s_axis_tuser,
    // Results.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // From bit 0: mapped_address[18:0], read_data[26:19], irq_line[27],
    // mirror_horizontal[28], zero fill[31:29].
    output logic [31:0] m_axis_tdata,
    // From bit 0: claimed[0], ram_access[1].
    output logic [1:0]  m_axis_tuser,
    // Configuration.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [5:0]  cfg_data
);

    localparam int RAM_AW = $clog2(WORK_RAM_BYTES);

    // Unpacked request fields.
    bsm_pkg::op_t op;
    logic [15:0]  address;
    logic [7:0]   write_data;
    logic [9:0]   scanline_row;
    logic [8:0]   dot_cycle;
    logic [7:0]   render_mask;

    assign op           = bsm_pkg::op_t'(s_axis_tuser);
    assign address      = s_axis_tdata[15:0];
    assign write_data   = s_axis_tdata[23:16];
    assign scanline_row = s_axis_tdata[33:24];
    assign dot_cycle    = s_axis_tdata[42:34];
    assign render_mask  = s_axis_tdata[50:43];

    // Mapper state. Bases are kept as bank numbers: the low address bits of
    // every translated access pass straight through.
    logic [5:0] prg_banks_reg,  prg_banks_next;
    logic [7:0] bank_select_reg, bank_select_next;
    logic [7:0] bank_regs_reg [8];
    logic [7:0] bank_regs_next [8];
    logic [5:0] prg_bank_reg [4];
    logic [5:0] prg_bank_next [4];
    logic [7:0] chr_bank_reg [8];
    logic [7:0] chr_bank_next [8];
    logic       mirror_reg,      mirror_next;
    logic [7:0] irq_latch_reg,   irq_latch_next;
    logic [7:0] irq_count_reg,   irq_count_next;
    logic       reload_pend_reg, reload_pend_next;
    logic       irq_en_reg,      irq_en_next;
    logic       irq_raised_reg,  irq_raised_next;

    // Clearing pass over the work RAM.
    logic              clr_active_reg, clr_active_next;
    logic [RAM_AW-1:0] clr_addr_reg,   clr_addr_next;

    // Result stage and skid register.
    logic                s1_valid_reg,   s1_valid_next;
    logic                skid_valid_reg, skid_valid_next;
    bsm_pkg::result_t    s1_res_reg;
    logic                s1_rd_reg;
    bsm_pkg::result_t    skid_res_reg;
    bsm_pkg::result_t    s1_res;
    bsm_pkg::result_t    out_res;
    bsm_pkg::result_t    new_res;

    logic              accept;
    logic              is_cpu;
    logic              is_wram;
    logic              is_reg;
    logic              reg_write;
    logic              ram_we;
    logic              ram_re;
    logic [RAM_AW-1:0] ram_addr;
    logic [7:0]        ram_wdata;
    logic [7:0]        ram_q;

    assign s_axis_tready = !skid_valid_reg && !clr_active_reg;
    assign cfg_ready     = 1'b1;
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign is_cpu    = (op == bsm_pkg::OP_CPU_READ) || (op == bsm_pkg::OP_CPU_WRITE);
    assign is_wram   = (address >= bsm_pkg::WRAM_LO) && (address <= bsm_pkg::WRAM_HI);
    assign is_reg    = address[15];
    assign reg_write = accept && (op == bsm_pkg::OP_CPU_WRITE) && is_reg;

    // Next mapper state: register writes, then the bank recompute, then ticks;
    // a size write reloads the fixed program layout.
    always_comb
    begin
        logic [5:0] mask;
        logic [2:0] one_k_idx;
        logic [2:0] two_k_idx;
        logic       visible;

        prg_banks_next   = prg_banks_reg;
        bank_select_next = bank_select_reg;
        bank_regs_next   = bank_regs_reg;
        prg_bank_next    = prg_bank_reg;
        chr_bank_next    = chr_bank_reg;
        mirror_next      = mirror_reg;
        irq_latch_next   = irq_latch_reg;
        irq_count_next   = irq_count_reg;
        reload_pend_next = reload_pend_reg;
        irq_en_next      = irq_en_reg;
        irq_raised_next  = irq_raised_reg;
        mask             = bsm_pkg::bank_last(prg_banks_reg);
        visible          = scanline_row[9] || (scanline_row < bsm_pkg::VISIBLE_ROWS);
        one_k_idx        = 3'd0;
        two_k_idx        = 3'd0;

        if (reg_write)
        begin
            case (bsm_pkg::reg_sel_t'({address[14:13], address[0]}))
                bsm_pkg::REG_BANK_SELECT: bank_select_next = write_data;
                bsm_pkg::REG_BANK_DATA:   bank_regs_next[bank_select_reg[2:0]] = write_data;
                bsm_pkg::REG_MIRROR:      mirror_next = write_data[0];
                bsm_pkg::REG_IRQ_LATCH:   irq_latch_next = write_data;
                bsm_pkg::REG_IRQ_RELOAD:
                begin
                    irq_count_next   = 8'd0;
                    reload_pend_next = 1'b1;
                end
                bsm_pkg::REG_IRQ_DISABLE:
                begin
                    irq_en_next     = 1'b0;
                    irq_raised_next = 1'b0;
                end
                bsm_pkg::REG_IRQ_ENABLE:  irq_en_next = 1'b1;
                default: ;
            endcase

            // Character banks: the 2 KB pairs sit in the lower or upper half.
            for (int n = 0; n < 4; n++)
            begin
                one_k_idx = 3'(n) + (bank_select_next[bsm_pkg::SEL_CHR_INVERT] ? 3'd0 : 3'd4);
                two_k_idx = 3'(n) + (bank_select_next[bsm_pkg::SEL_CHR_INVERT] ? 3'd4 : 3'd0);
                chr_bank_next[one_k_idx] = bank_regs_next[3'(n + 2)];
                chr_bank_next[two_k_idx] = {bank_regs_next[3'(n >> 1)][7:1], 1'(n)};
            end

            if (bank_select_next[bsm_pkg::SEL_PRG_SWAP])
            begin
                prg_bank_next[0] = bsm_pkg::bank_second_last(prg_banks_reg);
                prg_bank_next[2] = bank_regs_next[6][5:0] & mask;
            end
            else
            begin
                prg_bank_next[2] = bsm_pkg::bank_second_last(prg_banks_reg);
                prg_bank_next[0] = bank_regs_next[6][5:0] & mask;
            end
            prg_bank_next[1] = bank_regs_next[7][5:0] & mask;
        end

        if (accept && (op == bsm_pkg::OP_TICK) && visible && (dot_cycle == bsm_pkg::TICK_DOT)
            && ((render_mask & bsm_pkg::RENDER_BITS) != 8'd0))
        begin
            if ((irq_count_reg == 8'd0) || reload_pend_reg)
            begin
                irq_count_next   = irq_latch_reg;
                reload_pend_next = 1'b0;
            end
            else
            begin
                irq_count_next = irq_count_reg - 8'd1;
            end
            if ((irq_count_next == 8'd0) && irq_en_reg)
            begin
                irq_raised_next = 1'b1;
            end
        end

        if (cfg_valid)
        begin
            prg_banks_next   = cfg_data;
            prg_bank_next[0] = 6'd0;
            prg_bank_next[1] = 6'd1;
            prg_bank_next[2] = bsm_pkg::bank_second_last(cfg_data);
            prg_bank_next[3] = bsm_pkg::bank_last(cfg_data);
        end
    end

    // Result of the request being accepted; read data joins in the result stage.
    always_comb
    begin
        new_res                   = '0;
        new_res.irq_line          = irq_raised_next;
        new_res.mirror_horizontal = mirror_next;
        if (is_cpu && is_wram)
        begin
            new_res.claimed    = 1'b1;
            new_res.ram_access = 1'b1;
        end
        else if ((op == bsm_pkg::OP_CPU_READ) && is_reg)
        begin
            new_res.claimed        = 1'b1;
            new_res.mapped_address = {prg_bank_reg[address[14:13]], address[12:0]};
        end
        else if ((op == bsm_pkg::OP_VIDEO) && (address < bsm_pkg::VIDEO_TOP))
        begin
            new_res.claimed        = 1'b1;
            new_res.mapped_address = {1'b0, chr_bank_reg[address[12:10]], address[9:0]};
        end
    end

    // Work RAM port: the clearing pass owns it until it finishes.
    assign ram_we    = clr_active_reg || (accept && (op == bsm_pkg::OP_CPU_WRITE) && is_wram);
    assign ram_re    = accept && (op == bsm_pkg::OP_CPU_READ) && is_wram;
    assign ram_addr  = clr_active_reg ? clr_addr_reg : address[RAM_AW-1:0];
    assign ram_wdata = clr_active_reg ? 8'd0 : write_data;

    bsm_wram #(
        .DEPTH  (WORK_RAM_BYTES),
        .ADDR_W (RAM_AW)
    ) u_wram (
        .clk   (clk),
        .we    (ram_we),
        .re    (ram_re),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_q)
    );

    always_comb
    begin
        clr_active_next = clr_active_reg;
        clr_addr_next   = clr_addr_reg;
        if (clr_active_reg)
        begin
            clr_addr_next = clr_addr_reg + 1'b1;
            if (clr_addr_reg == RAM_AW'(WORK_RAM_BYTES - 1))
            begin
                clr_active_next = 1'b0;
            end
        end
    end

    // Read data is held by the RAM register because no read is issued while
    // the result stage is stalled behind a full skid register.
    always_comb
    begin
        s1_res           = s1_res_reg;
        s1_res.read_data = s1_rd_reg ? ram_q : 8'd0;
        out_res          = skid_valid_reg ? skid_res_reg : s1_res;
    end

    assign m_axis_tvalid = skid_valid_reg || s1_valid_reg;
    assign m_axis_tdata  = {3'b000, out_res.mirror_horizontal, out_res.irq_line,
                            out_res.read_data, out_res.mapped_address};
    assign m_axis_tuser  = {out_res.ram_access, out_res.claimed};

    always_comb
    begin
        s1_valid_next   = s1_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (skid_valid_reg)
        begin
            if (m_axis_tready)
            begin
                skid_valid_next = 1'b0;
            end
        end
        else if (accept)
        begin
            s1_valid_next = 1'b1;
            if (s1_valid_reg && !m_axis_tready)
            begin
                skid_valid_next = 1'b1;
            end
        end
        else if (m_axis_tready)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_res_reg <= new_res;
            s1_rd_reg  <= ram_re;
        end
        if (!skid_valid_reg && accept && s1_valid_reg && !m_axis_tready)
        begin
            skid_res_reg <= s1_res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prg_banks_reg   <= bsm_pkg::PRG_BANKS_RESET;
            bank_select_reg <= 8'd0;
            for (int n = 0; n < 8; n++)
            begin
                bank_regs_reg[3'(n)] <= 8'd0;
                chr_bank_reg[3'(n)]  <= 8'd0;
            end
            prg_bank_reg[0] <= 6'd0;
            prg_bank_reg[1] <= 6'd1;
            prg_bank_reg[2] <= bsm_pkg::bank_second_last(bsm_pkg::PRG_BANKS_RESET);
            prg_bank_reg[3] <= bsm_pkg::bank_last(bsm_pkg::PRG_BANKS_RESET);
            mirror_reg      <= 1'b1;
            irq_latch_reg   <= 8'd0;
            irq_count_reg   <= 8'd0;
            reload_pend_reg <= 1'b0;
            irq_en_reg      <= 1'b0;
            irq_raised_reg  <= 1'b0;
            clr_active_reg  <= 1'b1;
            clr_addr_reg    <= '0;
            s1_valid_reg    <= 1'b0;
            skid_valid_reg  <= 1'b0;
        end
        else
        begin
            prg_banks_reg   <= prg_banks_next;
            bank_select_reg <= bank_select_next;
            bank_regs_reg   <= bank_regs_next;
            prg_bank_reg    <= prg_bank_next;
            chr_bank_reg    <= chr_bank_next;
            mirror_reg      <= mirror_next;
            irq_latch_reg   <= irq_latch_next;
            irq_count_reg   <= irq_count_next;
            reload_pend_reg <= reload_pend_next;
            irq_en_reg      <= irq_en_next;
            irq_raised_reg  <= irq_raised_next;
            clr_active_reg  <= clr_active_next;
            clr_addr_reg    <= clr_addr_next;
            s1_valid_reg    <= s1_valid_next;
            skid_valid_reg  <= skid_valid_next;
        end
    end

endmodule
